### sv/lxt_pkg.sv
// shared types and constants for the local prefix xor transform
package lxt_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 4096;
  localparam int unsigned CTX_ROWS        = 256;
  localparam int unsigned ORDERS          = 3;
  localparam logic [1:0]  ORDER_MAX       = 2'd3;
  localparam logic [1:0]  ORDER_MIN       = 2'd1;
  localparam logic [15:0] MIN_THR_RST     = 16'd4;
  localparam logic [15:0] MAX_THR_RST     = 16'd256;

  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_MIN_THR   = 2'd1,
    CFG_MAX_THR   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_PRED2,
    S_HIST,
    S_UPD1,
    S_UPD2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] threshold;
    logic [23:0] suffix;
  } rec_t;

  typedef rec_t [ORDERS-1:0] row_t;

endpackage

### sv/lxt_ram.sv
// generic single write port ram with registered read
module lxt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/local_prefix_xor_transform.sv
// top level of the local prefix xor transform
// an accepted item steps through S_PRED to S_UPD2, then S_DONE loads the output register
// a new item waits for the last one, due to the serialized record and history ram accesses
// and the multi-step record update; the input waits while the output register stays full
// reset clears control state, all record rows read as cleared and registers take defaults
// history window ram is not cleared; WINDOW_SIZE must be a power of two
module local_prefix_xor_transform #(
  parameter int unsigned WINDOW_SIZE = lxt_pkg::WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        was_predicted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned HAW = $clog2(WINDOW_SIZE);

  lxt_pkg::state_t state, state_next;

  logic        direction;
  logic [15:0] min_thr, max_thr, clr_thr;
  logic [lxt_pkg::CTX_ROWS-1:0] row_valid;
  logic [31:0] ctx, pos, run_dist;
  logic [1:0]  order;
  logic        run;
  logic [7:0]  din;
  logic [7:0]  lp;
  logic [7:0]  plain, result;
  logic        pred;
  logic [31:0] prod, dist_u;
  logic signed [31:0] bound;
  logic        match, skip;
  logic [1:0]  order_new;
  lxt_pkg::row_t urow, nrow, urow_upd;

  logic [7:0]  t_raddr, t_raddr_q;
  logic [$bits(lxt_pkg::row_t)-1:0] t_rdata, t_wdata;
  logic        t_we;
  lxt_pkg::row_t row_eff, row_wr;
  lxt_pkg::rec_t rst_rec;
  logic [HAW-1:0] h_raddr;
  logic [7:0]  h_rdata;
  logic        h_we;

  logic [1:0]  oi;
  lxt_pkg::rec_t prec, ur, nr, r2;
  logic [31:0] pdist, rd_eff;
  logic        start;
  logic [7:0]  lp_c;
  logic [7:0]  res_c, plain_c, result_c;
  logic signed [31:0] distance, lower, upper, a_s, b_s, bound_c;
  logic [23:0] ls;
  logic [31:0] prod3;
  logic [1:0]  ord_c, oi2;

  lxt_ram #(.WIDTH($bits(lxt_pkg::row_t)), .DEPTH(lxt_pkg::CTX_ROWS)) u_table (
    .clk(clk), .we(t_we), .waddr(lp), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  lxt_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_hist (
    .clk(clk), .we(h_we), .waddr(pos[HAW-1:0]), .wdata(plain), .raddr(h_raddr),
    .rdata(h_rdata)
  );

  assign in_stall  = (state != lxt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rst_rec = '0;
    rst_rec.threshold = {16'd0, clr_thr};
    for (int i = 0; i < lxt_pkg::ORDERS; i++) begin
      row_eff[i] = row_valid[t_raddr_q] ? t_rdata[i*$bits(lxt_pkg::rec_t) +:
                                                  $bits(lxt_pkg::rec_t)] : rst_rec;
    end
  end

  // predict and lookup
  always_comb begin
    oi    = order - 2'd1;
    prec  = row_eff[oi];
    pdist = pos - prec.position;
    start = !run && (prec.hits > prec.threshold) && (pdist < 32'(WINDOW_SIZE));
    rd_eff = start ? pdist : run_dist;
    case (order)
      2'd1:    lp_c = ctx[15:8];
      2'd2:    lp_c = ctx[23:16];
      default: lp_c = ctx[31:24];
    endcase
    case (order)
      2'd1:    ls = {16'd0, ctx[7:0]};
      2'd2:    ls = {8'd0, ctx[15:0]};
      default: ls = ctx[23:0];
    endcase
  end

  // history combine
  always_comb begin
    if (run) begin
      if (!direction) begin
        plain_c  = din;
        res_c    = din ^ h_rdata;
        result_c = res_c;
      end else begin
        res_c    = din;
        plain_c  = din ^ h_rdata;
        result_c = plain_c;
      end
    end else begin
      res_c    = 8'd0;
      plain_c  = din;
      result_c = din;
    end
  end

  // record update, first step
  always_comb begin
    ur       = urow[oi];
    distance = $signed(dist_u);
    lower    = $signed({16'd0, min_thr});
    a_s      = $signed(dist_u) >>> order;
    b_s      = $signed({16'd0, max_thr} >> order);
    if (ur.hits < {16'd0, max_thr}) begin
      upper = (distance > lower) ? distance : lower;
    end else begin
      upper = (a_s < b_s) ? a_s : b_s;
    end
    if (distance <= lower) begin
      bound_c = lower;
    end else if (distance > upper) begin
      bound_c = upper;
    end else begin
      bound_c = distance;
    end
    case (order)
      2'd1:    prod3 = prod;
      2'd2:    prod3 = prod << 1;
      default: prod3 = prod + (prod << 1);
    endcase
    nr = ur;
    ord_c = order;
    if (ur.suffix == ls) begin
      nr.position = pos - {30'd0, order};
      nr.hits     = ur.hits + 32'd1;
      nr.misses   = 32'd0;
      if ((nr.hits > (ur.threshold << (3'(order) + 3'd3))) && (order > lxt_pkg::ORDER_MIN)) begin
        ord_c = order - 2'd1;
      end
    end else begin
      nr.hits   = ur.hits >> 2;
      nr.misses = ur.misses + 32'd1;
      nr.suffix = ls;
      if ((nr.misses > prod3) && (order < lxt_pkg::ORDER_MAX)) begin
        ord_c = order + 2'd1;
      end
    end
    urow_upd     = urow;
    urow_upd[oi] = nr;
  end

  // record update, threshold step
  always_comb begin
    oi2 = order_new - 2'd1;
    r2  = nrow[oi2];
    row_wr = nrow;
    if (match) begin
      if ((r2.hits > (r2.threshold << 1)) && (r2.misses == 32'd0)) begin
        row_wr[oi2].threshold = r2.threshold +
          32'($signed(32'(bound) - r2.threshold) >>> order_new);
      end
    end else if (r2.misses > r2.threshold) begin
      row_wr[oi2].threshold = r2.threshold +
        32'($signed({16'd0, max_thr} - r2.threshold) >>> (3'd4 - 3'(order_new)));
    end
    t_wdata = row_wr;
  end

  always_comb begin
    state_next = state;
    t_raddr = ctx[7:0];
    h_raddr = pos[HAW-1:0] - rd_eff[HAW-1:0];
    t_we = 1'b0;
    h_we = 1'b0;
    case (state)
      lxt_pkg::S_IDLE:  if (in_valid) state_next = lxt_pkg::S_PRED;
      lxt_pkg::S_PRED:  state_next = lxt_pkg::S_PRED2;
      lxt_pkg::S_PRED2: begin
        t_raddr = lp_c;
        state_next = lxt_pkg::S_HIST;
      end
      lxt_pkg::S_HIST:  state_next = lxt_pkg::S_UPD1;
      lxt_pkg::S_UPD1: begin
        h_we = 1'b1;
        state_next = lxt_pkg::S_UPD2;
      end
      lxt_pkg::S_UPD2: begin
        t_we = !skip;
        state_next = lxt_pkg::S_DONE;
      end
      lxt_pkg::S_DONE:  if (!out_valid || !out_stall) state_next = lxt_pkg::S_IDLE;
      default:          state_next = lxt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lxt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    t_raddr_q <= t_raddr;
    if (rst) begin
      direction <= 1'b0;
      min_thr   <= lxt_pkg::MIN_THR_RST;
      max_thr   <= lxt_pkg::MAX_THR_RST;
      clr_thr   <= lxt_pkg::MAX_THR_RST >> 1;
      row_valid <= '0;
      ctx       <= '0;
      pos       <= '0;
      order     <= lxt_pkg::ORDER_MAX;
      run       <= 1'b0;
      run_dist  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lxt_pkg::CFG_DIRECTION: direction <= cfg_data[0];
          lxt_pkg::CFG_MIN_THR:   min_thr   <= cfg_data;
          lxt_pkg::CFG_MAX_THR:   max_thr   <= cfg_data;
          default: ;
        endcase
      end
      if ((state == lxt_pkg::S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        lxt_pkg::S_IDLE: begin
          if (in_valid) begin
            din <= data_byte;
            if (block_start) begin
              clr_thr   <= max_thr >> 1;
              row_valid <= '0;
              ctx       <= '0;
              pos       <= '0;
              order     <= lxt_pkg::ORDER_MAX;
              run       <= 1'b0;
              run_dist  <= '0;
            end
          end
        end
        lxt_pkg::S_PRED2: begin
          lp <= lp_c;
          if (start) begin
            run      <= 1'b1;
            run_dist <= pdist;
          end
        end
        lxt_pkg::S_HIST: begin
          urow   <= row_eff;
          prod   <= 32'(row_eff[oi].threshold * row_eff[oi].threshold);
          dist_u <= pos - row_eff[oi].position;
          plain  <= plain_c;
          result <= result_c;
          pred   <= run;
          if (run && (res_c != 8'd0)) begin
            run <= 1'b0;
          end
        end
        lxt_pkg::S_UPD1: begin
          nrow          <= urow_upd;
          bound         <= bound_c;
          match         <= (ur.suffix == ls);
          skip          <= (pos <= {30'd0, order});
          order_new     <= ord_c;
        end
        lxt_pkg::S_UPD2: begin
          if (!skip) begin
            row_valid[lp] <= 1'b1;
            order         <= order_new;
          end
          ctx <= {ctx[23:0], plain};
          pos <= pos + 32'd1;
        end
        lxt_pkg::S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_byte      <= result;
            was_predicted <= pred;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
